### src/rcrb_pkg.sv
// Shared types, operation codes and constants of the reset controller register bank.
package rcrb_pkg;

   // Operation codes of a request beat.
   localparam logic [2:0] OP_READ       = 3'd0;
   localparam logic [2:0] OP_WRITE      = 3'd1;
   localparam logic [2:0] OP_COLD       = 3'd2;
   localparam logic [2:0] OP_WARM       = 3'd3;
   localparam logic [2:0] OP_WATCHDOG   = 3'd4;
   localparam logic [2:0] OP_RESET_LINE = 3'd5;

   // Access size codes.
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   // Word indexes with special behavior.
   localparam logic [11:0] CONTROL_WORD     = 12'd0;
   localparam logic [11:0] STATUS_WORD      = 12'd2;
   localparam logic [11:0] SOURCE_MASK_WORD = 12'd6;

   localparam logic [31:0] CONTROL_SELF_CLEAR = 32'h0000_E00E;
   localparam logic [31:0] CONTROL_RESET      = 32'h0000_0521;
   localparam logic [31:0] SOURCE_MASK_RESET  = 32'h0000_001F;
   localparam logic [31:0] STATUS_POWER_ON    = 32'h0000_0001;
   localparam logic [31:0] STATUS_WATCHDOG    = 32'h0000_0010;
   localparam logic [31:0] STATUS_WARM        = 32'h0001_0000;
   localparam logic [31:0] BYTE_LANE          = 32'h0000_00FF;
   localparam logic [31:0] HALF_LANE          = 32'h0000_FFFF;

   typedef struct packed {
      logic [2:0]  operation;
      logic [13:0] offset;
      logic [1:0]  access_size;
      logic [31:0] write_data;
   } req_type;

   // Side effects of one executed beat.
   typedef struct packed {
      logic        bank_we;
      logic [31:0] bank_wdata;
      logic        status_we;
      logic [31:0] status_next;
      logic        reload;
   } act_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        access_error;
   } rsp_type;

   // Reset value of a bank word.
   function automatic logic [31:0] reset_word(input logic [11:0] word);
      logic [31:0] value;
      value = '0;
      if (word == CONTROL_WORD) begin
         value = CONTROL_RESET;
      end else if (word == SOURCE_MASK_WORD) begin
         value = SOURCE_MASK_RESET;
      end
      return value;
   endfunction

endpackage

### src/rcrb_exec.sv
// Decode, lane merge and side-effect generation for one register access.
module rcrb_exec import rcrb_pkg::*; #(
   parameter int REGISTER_WORDS = 18
) (
   input  req_type     req,
   input  logic [31:0] cur_word,
   input  logic [31:0] status,
   output act_type     act,
   output rsp_type     result
);

   localparam logic [11:0] WORDS_C = 12'(REGISTER_WORDS);

   logic [11:0] word;
   logic [4:0]  shift;
   logic        bad;
   logic [31:0] lane;
   logic [31:0] mask;
   logic [31:0] shifted;
   logic [31:0] merged;

   assign word    = req.offset[13:2];
   assign shift   = {req.offset[1:0], 3'b000};
   assign shifted = cur_word >> shift;

   always_comb begin
      bad  = 1'b0;
      lane = HALF_LANE;
      unique case (req.access_size)
         SIZE_BYTE: lane = BYTE_LANE;
         SIZE_HALF: bad  = req.offset[0];
         SIZE_WORD: bad  = (req.offset[1:0] != 2'b00);
         default:   bad  = 1'b1;
      endcase
      if (word >= WORDS_C) begin
         bad = 1'b1;
      end
   end

   assign mask   = lane << shift;
   assign merged = (req.access_size == SIZE_WORD) ? req.write_data :
                   ((cur_word & ~mask) | ((req.write_data << shift) & mask));

   always_comb begin
      act    = '0;
      result = '0;
      unique case (req.operation)
         OP_READ, OP_WRITE: begin
            if (bad) begin
               result.access_error = 1'b1;
            end else if (req.operation == OP_READ) begin
               if (req.access_size == SIZE_WORD) begin
                  result.read_data = shifted;
               end else begin
                  result.read_data = shifted & lane;
               end
            end else if (word == STATUS_WORD) begin
               // Write-one-to-clear, using the whole merged word.
               act.status_we   = 1'b1;
               act.status_next = status & ~merged;
            end else begin
               act.bank_we    = 1'b1;
               act.bank_wdata = (word == CONTROL_WORD) ? (merged & ~CONTROL_SELF_CLEAR)
                                                       : merged;
            end
         end
         OP_COLD: begin
            act.status_we   = 1'b1;
            act.status_next = STATUS_POWER_ON;
         end
         OP_WARM: begin
            act.status_we   = 1'b1;
            act.status_next = STATUS_WARM;
         end
         OP_WATCHDOG: begin
            act.status_we   = 1'b1;
            act.status_next = STATUS_WATCHDOG;
         end
         OP_RESET_LINE: begin
            act.reload = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

### src/reset_controller_register_bank.sv
// Top level of the reset controller register bank.
//
// A request beat carries an operation (read, write, one of three reset causes,
// or a reset-line event), a byte offset, an access size and write data. Every
// request beat yields exactly one response beat with the read data and an
// access error flag.
// The bank words live in a synchronous memory. The word is read at the edge
// that accepts the request; when the stage finishes, the lane is merged and
// written back and the response register is loaded. A new request is accepted
// in that same cycle, which sustains one beat per clock while responses are
// taken. When the next access reads the word just written, the written value
// is forwarded. The reset status word sits in its own register. A valid bit
// per bank word tells whether the word has been written since the last
// reload; a word that is not valid reads as its reset value, so a reset-line
// event need only clear the valid bits. Reset empties the pipeline, clears
// all valid bits and sets the power-on bit of the status word. When the
// receiver stalls, the response is held and the pending request waits in its
// stage, so at most one request waits behind the response.
module reset_controller_register_bank import rcrb_pkg::*; #(
   parameter int REGISTER_WORDS = 18
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [13:0] req_offset,
   input  logic [1:0]  req_access_size,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_access_error
);

   localparam int          IdxW    = $clog2(REGISTER_WORDS);
   localparam logic [11:0] WORDS_C = 12'(REGISTER_WORDS);

   logic [31:0]               bank_ff [REGISTER_WORDS];
   logic [31:0]               mem_q_ff;
   logic [REGISTER_WORDS-1:0] valid_ff;
   logic [31:0]               status_ff;
   req_type                   req_ff;
   logic [IdxW-1:0]           idx_ff;
   logic                      busy_ff;
   logic                      fwd_ff;
   logic [31:0]               fwd_data_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;

   logic            accept;
   logic            done;
   logic            busy_in;
   logic [IdxW-1:0] idx_in;
   logic            fwd_in;
   req_type         req_in;
   logic [31:0]     cur_word;
   act_type         act;
   rsp_type         result;

   // The stage finishes when the response register is free or being drained.
   assign done      = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !busy_ff || done;
   assign accept    = req_valid && req_ready;
   assign busy_in   = accept || (busy_ff && !done);

   assign req_in = '{operation:   req_operation,
                     offset:      req_offset,
                     access_size: req_access_size,
                     write_data:  req_write_data};

   // Out-of-range offsets read word zero; their result is an error anyway.
   assign idx_in = (req_offset[13:2] < WORDS_C) ? req_offset[IdxW+1:2] : '0;
   assign fwd_in = done && act.bank_we && (idx_ff == idx_in);

   always_comb begin
      if (req_ff.offset[13:2] == STATUS_WORD) begin
         cur_word = status_ff;
      end else if (fwd_ff) begin
         cur_word = fwd_data_ff;
      end else if (valid_ff[idx_ff]) begin
         cur_word = mem_q_ff;
      end else begin
         cur_word = reset_word(req_ff.offset[13:2]);
      end
   end

   rcrb_exec #(
      .REGISTER_WORDS(REGISTER_WORDS)
   ) u_exec (
      .req      (req_ff),
      .cur_word (cur_word),
      .status   (status_ff),
      .act      (act),
      .result   (result)
   );

   // Bank memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (done && act.bank_we) begin
         bank_ff[idx_ff] <= act.bank_wdata;
      end
      if (accept) begin
         mem_q_ff <= bank_ff[idx_in];
      end
   end

   // Request stage payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff      <= req_in;
         idx_ff      <= idx_in;
         fwd_data_ff <= act.bank_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fwd_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (accept) begin
            fwd_ff <= fwd_in;
         end else if (done) begin
            // The stage drains with nothing behind it.
            fwd_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         status_ff <= STATUS_POWER_ON;
      end else if (done) begin
         if (act.reload) begin
            valid_ff <= '0;
         end else if (act.bank_we) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         if (act.status_we) begin
            status_ff <= act.status_next;
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_ff.read_data;
   assign rsp_access_error = rsp_ff.access_error;

   // A finished access always leaves a response behind.
   assert property (@(posedge clock) disable iff (reset) done |=> rsp_valid_ff)
      else $error("finished access did not load the response register");

   // The status word is never written into the bank memory.
   assert property (@(posedge clock) disable iff (reset)
      act.bank_we |-> (req_ff.offset[13:2] != STATUS_WORD))
      else $error("bank write aimed at the status word");

   // An error response never comes with read data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.access_error) |-> (rsp_ff.read_data == '0))
      else $error("error response carries read data");

   // A cold cause leaves exactly the power-on bit set.
   assert property (@(posedge clock) disable iff (reset)
      (done && (req_ff.operation == OP_COLD)) |=> (status_ff == STATUS_POWER_ON))
      else $error("cold cause did not set the power-on status");

   // Forwarding is only armed when the stage also accepted a request.
   assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> busy_ff)
      else $error("forwarding armed with an empty stage");

endmodule
